/* hdl/pgmdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgmdf_pkg
// Shared types and constants for the 16-bit graymap stream deframer.
// ----------------------------------------------------------------------------
package pgmdf_pkg;

    // Largest frame accepted, in pixels (2^24).
    localparam logic [32:0] MAX_PIXELS = 33'd16777216;

    localparam logic [7:0] BYTE_P     = 8'h50;
    localparam logic [7:0] BYTE_5     = 8'h35;
    localparam logic [7:0] LINE_FEED  = 8'h0A;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    localparam logic [19:0] DIM_LIMIT    = 20'd65535;
    localparam logic [16:0] MAXVAL_16BIT = 17'd65535;
    localparam logic [20:0] MAXVAL_SAT   = 21'd65536;

    typedef enum logic [3:0] {
        PH_MAGIC_P  = 4'd0,
        PH_MAGIC_5  = 4'd1,
        PH_MAGIC_LF = 4'd2,
        PH_WIDTH    = 4'd3,
        PH_HEIGHT   = 4'd4,
        PH_MAXVAL   = 4'd5,
        PH_PIX_HIGH = 4'd6,
        PH_PIX_LOW  = 4'd7,
        PH_DONE     = 4'd8,
        PH_ERROR    = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER     = 3'd0,
        KIND_PIXEL      = 3'd1,
        KIND_BAD_MAGIC  = 3'd2,
        KIND_BAD_NUMBER = 3'd3,
        KIND_NOT16      = 3'd4,
        KIND_TOO_LARGE  = 3'd5
    } kind_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [15:0] pixel_value;
        logic [23:0] pixel_address;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        last_pixel;
    } result_t;

endpackage

/* hdl/pgmdf_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgmdf_parser
// Header parse state machine and pixel address counters, one byte per cycle while in_fire is high.
// ----------------------------------------------------------------------------
module pgmdf_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic [7:0]          data_byte,
    input  logic                start_of_file,
    output pgmdf_pkg::result_t  result
);

    pgmdf_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [15:0] width_reg, width_next, width_cur;
    logic [15:0] height_reg, height_next, height_cur;
    logic [16:0] maxval_reg, maxval_next, maxval_cur;
    logic [23:0] row_base_reg, row_base_next;
    logic [15:0] column_reg, column_next;
    logic [15:0] rows_left_reg, rows_left_next;
    logic [7:0]  high_byte_reg, high_byte_next;
    logic [31:0] prod_reg;

    logic        is_digit;
    logic [3:0]  digit;
    logic [19:0] width_acc, height_acc;
    logic [20:0] maxval_acc;
    logic        frame_big, frame_zero;
    logic [15:0] column_inc;
    logic        row_end;
    logic [15:0] rows_dec;

    // start_of_file restarts the parse on this very byte
    assign phase_cur  = start_of_file ? pgmdf_pkg::PH_MAGIC_P : phase_reg;
    assign width_cur  = start_of_file ? 16'd0 : width_reg;
    assign height_cur = start_of_file ? 16'd0 : height_reg;
    assign maxval_cur = start_of_file ? 17'd0 : maxval_reg;

    assign is_digit = (data_byte >= pgmdf_pkg::DIGIT_ZERO) &&
                      (data_byte <= pgmdf_pkg::DIGIT_NINE);
    assign digit    = 4'(data_byte - pgmdf_pkg::DIGIT_ZERO);

    assign width_acc  = ({4'd0, width_cur} << 3) + ({4'd0, width_cur} << 1)
                      + {16'd0, digit};
    assign height_acc = ({4'd0, height_cur} << 3) + ({4'd0, height_cur} << 1)
                      + {16'd0, digit};
    assign maxval_acc = ({4'd0, maxval_cur} << 3) + ({4'd0, maxval_cur} << 1)
                      + {17'd0, digit};

    // prod_reg settles while the maxval line is read
    assign frame_big  = {1'b0, prod_reg} > pgmdf_pkg::MAX_PIXELS;
    assign frame_zero = (prod_reg == 32'd0);

    assign column_inc = column_reg + 16'd1;
    assign row_end    = (column_inc >= width_reg);
    assign rows_dec   = rows_left_reg - 16'd1;

    // next phase
    always_comb begin
        phase_next = phase_cur;
        case (phase_cur)
            pgmdf_pkg::PH_MAGIC_P: begin
                phase_next = (data_byte == pgmdf_pkg::BYTE_P) ?
                             pgmdf_pkg::PH_MAGIC_5 : pgmdf_pkg::PH_ERROR;
            end
            pgmdf_pkg::PH_MAGIC_5: begin
                phase_next = (data_byte == pgmdf_pkg::BYTE_5) ?
                             pgmdf_pkg::PH_MAGIC_LF : pgmdf_pkg::PH_ERROR;
            end
            pgmdf_pkg::PH_MAGIC_LF: begin
                phase_next = (data_byte == pgmdf_pkg::LINE_FEED) ?
                             pgmdf_pkg::PH_WIDTH : pgmdf_pkg::PH_ERROR;
            end
            pgmdf_pkg::PH_WIDTH: begin
                if (data_byte == pgmdf_pkg::SPACE_BYTE) begin
                    phase_next = pgmdf_pkg::PH_HEIGHT;
                end else if (!is_digit || width_acc > pgmdf_pkg::DIM_LIMIT) begin
                    phase_next = pgmdf_pkg::PH_ERROR;
                end
            end
            pgmdf_pkg::PH_HEIGHT: begin
                if (data_byte == pgmdf_pkg::LINE_FEED) begin
                    phase_next = pgmdf_pkg::PH_MAXVAL;
                end else if (!is_digit || height_acc > pgmdf_pkg::DIM_LIMIT) begin
                    phase_next = pgmdf_pkg::PH_ERROR;
                end
            end
            pgmdf_pkg::PH_MAXVAL: begin
                if (data_byte == pgmdf_pkg::LINE_FEED) begin
                    if (maxval_cur != pgmdf_pkg::MAXVAL_16BIT || frame_big) begin
                        phase_next = pgmdf_pkg::PH_ERROR;
                    end else if (frame_zero) begin
                        phase_next = pgmdf_pkg::PH_DONE;
                    end else begin
                        phase_next = pgmdf_pkg::PH_PIX_HIGH;
                    end
                end else if (!is_digit) begin
                    phase_next = pgmdf_pkg::PH_ERROR;
                end
            end
            pgmdf_pkg::PH_PIX_HIGH: begin
                phase_next = pgmdf_pkg::PH_PIX_LOW;
            end
            pgmdf_pkg::PH_PIX_LOW: begin
                phase_next = (row_end && rows_dec == 16'd0) ?
                             pgmdf_pkg::PH_DONE : pgmdf_pkg::PH_PIX_HIGH;
            end
            default: begin
                phase_next = phase_cur;
            end
        endcase
    end

    // datapath registers
    always_comb begin
        width_next     = width_cur;
        height_next    = height_cur;
        maxval_next    = maxval_cur;
        row_base_next  = start_of_file ? 24'd0 : row_base_reg;
        column_next    = start_of_file ? 16'd0 : column_reg;
        rows_left_next = start_of_file ? 16'd0 : rows_left_reg;
        high_byte_next = start_of_file ? 8'd0 : high_byte_reg;
        case (phase_cur)
            pgmdf_pkg::PH_WIDTH: begin
                if (is_digit && width_acc <= pgmdf_pkg::DIM_LIMIT) begin
                    width_next = width_acc[15:0];
                end
            end
            pgmdf_pkg::PH_HEIGHT: begin
                if (is_digit && height_acc <= pgmdf_pkg::DIM_LIMIT) begin
                    height_next = height_acc[15:0];
                end
            end
            pgmdf_pkg::PH_MAXVAL: begin
                if (data_byte == pgmdf_pkg::LINE_FEED) begin
                    column_next    = 16'd0;
                    rows_left_next = height_cur;
                    // (h - 1) * w taken as h * w - w
                    row_base_next  = (height_cur == 16'd0) ? 24'd0 :
                                     prod_reg[23:0] - {8'd0, width_cur};
                end else if (is_digit) begin
                    maxval_next = (maxval_acc > pgmdf_pkg::MAXVAL_SAT) ?
                                  pgmdf_pkg::MAXVAL_SAT[16:0] : maxval_acc[16:0];
                end
            end
            pgmdf_pkg::PH_PIX_HIGH: begin
                high_byte_next = data_byte;
            end
            pgmdf_pkg::PH_PIX_LOW: begin
                if (row_end) begin
                    column_next    = 16'd0;
                    rows_left_next = rows_dec;
                    row_base_next  = row_base_reg - {8'd0, width_reg};
                end else begin
                    column_next = column_inc;
                end
            end
            default: begin
                width_next = width_cur;
            end
        endcase
    end

    // result for this byte
    always_comb begin
        result = '0;
        result.kind = pgmdf_pkg::KIND_HEADER;
        case (phase_cur)
            pgmdf_pkg::PH_MAGIC_P: begin
                result.valid = (data_byte != pgmdf_pkg::BYTE_P);
                result.kind  = pgmdf_pkg::KIND_BAD_MAGIC;
            end
            pgmdf_pkg::PH_MAGIC_5: begin
                result.valid = (data_byte != pgmdf_pkg::BYTE_5);
                result.kind  = pgmdf_pkg::KIND_BAD_MAGIC;
            end
            pgmdf_pkg::PH_MAGIC_LF: begin
                result.valid = (data_byte != pgmdf_pkg::LINE_FEED);
                result.kind  = pgmdf_pkg::KIND_BAD_MAGIC;
            end
            pgmdf_pkg::PH_WIDTH: begin
                if (data_byte != pgmdf_pkg::SPACE_BYTE) begin
                    if (!is_digit) begin
                        result.valid = 1'b1;
                        result.kind  = pgmdf_pkg::KIND_BAD_NUMBER;
                    end else if (width_acc > pgmdf_pkg::DIM_LIMIT) begin
                        result.valid = 1'b1;
                        result.kind  = pgmdf_pkg::KIND_TOO_LARGE;
                    end
                end
            end
            pgmdf_pkg::PH_HEIGHT: begin
                if (data_byte != pgmdf_pkg::LINE_FEED) begin
                    if (!is_digit) begin
                        result.valid = 1'b1;
                        result.kind  = pgmdf_pkg::KIND_BAD_NUMBER;
                    end else if (height_acc > pgmdf_pkg::DIM_LIMIT) begin
                        result.valid = 1'b1;
                        result.kind  = pgmdf_pkg::KIND_TOO_LARGE;
                    end
                end
            end
            pgmdf_pkg::PH_MAXVAL: begin
                if (data_byte == pgmdf_pkg::LINE_FEED) begin
                    result.valid = 1'b1;
                    if (maxval_cur != pgmdf_pkg::MAXVAL_16BIT) begin
                        result.kind = pgmdf_pkg::KIND_NOT16;
                    end else if (frame_big) begin
                        result.kind = pgmdf_pkg::KIND_TOO_LARGE;
                    end else begin
                        result.kind         = pgmdf_pkg::KIND_HEADER;
                        result.image_width  = width_cur;
                        result.image_height = height_cur;
                    end
                end else if (!is_digit) begin
                    result.valid = 1'b1;
                    result.kind  = pgmdf_pkg::KIND_BAD_NUMBER;
                end
            end
            pgmdf_pkg::PH_PIX_LOW: begin
                result.valid         = 1'b1;
                result.kind          = pgmdf_pkg::KIND_PIXEL;
                result.pixel_value   = {high_byte_reg, data_byte};
                result.pixel_address = row_base_reg + {8'd0, column_reg};
                result.last_pixel    = row_end && (rows_dec == 16'd0);
            end
            default: begin
                result.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= pgmdf_pkg::PH_MAGIC_P;
            width_reg     <= 16'd0;
            height_reg    <= 16'd0;
            maxval_reg    <= 17'd0;
            row_base_reg  <= 24'd0;
            column_reg    <= 16'd0;
            rows_left_reg <= 16'd0;
            high_byte_reg <= 8'd0;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            maxval_reg    <= maxval_next;
            row_base_reg  <= row_base_next;
            column_reg    <= column_next;
            rows_left_reg <= rows_left_next;
            high_byte_reg <= high_byte_next;
        end
    end

    // frame size, registered from the dimension registers
    always_ff @(posedge aclk) begin
        prod_reg <= width_reg * height_reg;
    end

endmodule

/* hdl/pgmdf_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgmdf_out_reg
// Result register holding one item until the downstream side takes it.
// ----------------------------------------------------------------------------
module pgmdf_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  pgmdf_pkg::result_t  result_in,
    input  logic                out_ready,
    output logic                out_valid,
    output pgmdf_pkg::result_t  result_out
);

    logic               valid_reg, valid_next;
    pgmdf_pkg::result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = result_in.valid;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

/* hdl/pgm16_stream_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm16_stream_deframer
// Byte-serial parser for 16-bit binary graymap files with mirrored addresses.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser        | tlast
//  s_      | in  | [7:0] data_byte               | start_of_file| -
//  m_      | out | value/address/width/height    | result_kind  | last_pixel
//
//  One byte is taken per cycle while s_tready is high; a result, when the byte
//  makes one, appears on m_ in the cycle after the byte is accepted.
//  Reset (aresetn low, synchronous) returns the parser to the magic 'P'.
//  A stalled m_ side holds the result register; s_tready stays high while
//  the register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module pgm16_stream_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [15:0] pixel_value, [39:16] pixel_address,
                                   // [55:40] image_width, [71:56] image_height
    output logic [2:0]  m_tuser,   // [2:0] result_kind
    output logic        m_tlast    // last_pixel
);

    logic               in_fire;
    pgmdf_pkg::result_t parse_result;
    pgmdf_pkg::result_t out_result;

    // accept while the result register is free or draining
    assign s_tready = !m_tvalid || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    pgmdf_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .data_byte     (s_tdata),
        .start_of_file (s_tuser),
        .result        (parse_result)
    );

    // hold each result until the downstream side takes it
    pgmdf_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (in_fire),
        .result_in  (parse_result),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .result_out (out_result)
    );

    assign m_tdata = {out_result.image_height, out_result.image_width,
                      out_result.pixel_address, out_result.pixel_value};
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.last_pixel;

`ifndef SYNTH
    a_last_is_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == pgmdf_pkg::KIND_PIXEL)
        else $error("last_pixel set on a non-pixel result");

    a_non_pixel_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != pgmdf_pkg::KIND_PIXEL |-> m_tdata[39:0] == 40'd0)
        else $error("pixel fields set on a non-pixel result");

    a_err_no_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != pgmdf_pkg::KIND_HEADER |-> m_tdata[71:40] == 32'd0)
        else $error("dimensions set on a result other than header accepted");

    a_fire_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid && !parse_result.valid |=> !m_tvalid)
        else $error("result appeared for a byte that made none");
`endif

endmodule

/* bench/tb_pgm16_stream_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pgm16_stream_deframer
// Self-checking bench for the 16-bit graymap stream deframer. A short table
// of directed bytes comes first, then randomly built graymap files (mostly
// well-formed, with broken headers and noise mixed in). Each byte the block
// accepts runs through a parser model in the bench; the results it predicts
// are queued and compared field by field with every result the block emits.
// Both stream sides idle and stall at random, in several phases.
// ----------------------------------------------------------------------------
module tb_pgm16_stream_deframer;

    localparam int DIRECTED_ROWS = 25;
    localparam int N_ITEMS       = 1300;   // random bytes after the table
    localparam int LONG_HOLD     = 200;    // receiver hold-off, in cycles
    localparam int WATCHDOG      = 2000;   // cycles with no item moving
    localparam int DRAIN_CYCLES  = 16;
    localparam int SC_COUNT      = 10;

    // header field that receives a corrupt byte
    localparam int NO_FIELD     = -1;
    localparam int FIELD_WIDTH  = 0;
    localparam int FIELD_HEIGHT = 1;
    localparam int FIELD_MAXVAL = 2;

    // kinds of generated file
    typedef enum int {
        SC_GOOD, SC_WIDE, SC_TRUNC, SC_BAD_MAGIC, SC_BAD_NUMBER,
        SC_OVERFLOW, SC_MAXVAL, SC_TOO_LARGE, SC_BOUNDARY, SC_NOISE
    } scen_t;

    localparam pgmdf_pkg::result_t NO_RESULT =
        '{1'b0, pgmdf_pkg::KIND_HEADER, 16'd0, 24'd0, 16'd0, 16'd0, 1'b0};
    localparam pgmdf_pkg::result_t R_BAD_MAGIC =
        '{1'b1, pgmdf_pkg::KIND_BAD_MAGIC, 16'd0, 24'd0, 16'd0, 16'd0, 1'b0};
    localparam pgmdf_pkg::result_t R_BAD_NUMBER =
        '{1'b1, pgmdf_pkg::KIND_BAD_NUMBER, 16'd0, 24'd0, 16'd0, 16'd0, 1'b0};
    localparam pgmdf_pkg::result_t R_HDR_1X1 =
        '{1'b1, pgmdf_pkg::KIND_HEADER, 16'd0, 24'd0, 16'd1, 16'd1, 1'b0};
    localparam pgmdf_pkg::result_t R_PIX_MAX =
        '{1'b1, pgmdf_pkg::KIND_PIXEL, 16'hFFFF, 24'd0, 16'd0, 16'd0, 1'b1};

    // one directed byte; typed rows carry their result, the rest use the model
    typedef struct packed {
        logic [7:0]         data;
        logic               sof;
        logic               typed;
        pgmdf_pkg::result_t res;
    } dir_row_t;

    dir_row_t dir_table [DIRECTED_ROWS] = '{
        '{8'h51,                 1'b1, 1'b1, R_BAD_MAGIC},   // 'Q' where 'P' belongs
        '{8'h00,                 1'b0, 1'b1, NO_RESULT},     // error holds
        '{pgmdf_pkg::BYTE_P,     1'b1, 1'b0, NO_RESULT},     // minimal 1x1 file
        '{pgmdf_pkg::BYTE_5,     1'b0, 1'b0, NO_RESULT},
        '{pgmdf_pkg::LINE_FEED,  1'b0, 1'b0, NO_RESULT},
        '{8'h31,                 1'b0, 1'b0, NO_RESULT},     // width 1
        '{pgmdf_pkg::SPACE_BYTE, 1'b0, 1'b0, NO_RESULT},
        '{8'h31,                 1'b0, 1'b0, NO_RESULT},     // height 1
        '{pgmdf_pkg::LINE_FEED,  1'b0, 1'b0, NO_RESULT},
        '{8'h36,                 1'b0, 1'b0, NO_RESULT},     // maxval 65535
        '{8'h35,                 1'b0, 1'b0, NO_RESULT},
        '{8'h35,                 1'b0, 1'b0, NO_RESULT},
        '{8'h33,                 1'b0, 1'b0, NO_RESULT},
        '{8'h35,                 1'b0, 1'b0, NO_RESULT},
        '{pgmdf_pkg::LINE_FEED,  1'b0, 1'b1, R_HDR_1X1},
        '{8'hFF,                 1'b0, 1'b0, NO_RESULT},     // full-scale pixel
        '{8'hFF,                 1'b0, 1'b1, R_PIX_MAX},
        '{8'h00,                 1'b0, 1'b1, NO_RESULT},     // past the frame: silent
        '{pgmdf_pkg::BYTE_P,     1'b1, 1'b0, NO_RESULT},
        '{pgmdf_pkg::BYTE_5,     1'b0, 1'b0, NO_RESULT},
        '{pgmdf_pkg::LINE_FEED,  1'b0, 1'b0, NO_RESULT},
        '{8'h3A,                 1'b0, 1'b1, R_BAD_NUMBER},  // ':' sits just above '9'
        '{pgmdf_pkg::BYTE_P,     1'b0, 1'b1, NO_RESULT},     // no restart without sof
        '{pgmdf_pkg::BYTE_P,     1'b1, 1'b0, NO_RESULT},
        '{8'h34,                 1'b0, 1'b1, R_BAD_MAGIC}    // 'P4' is not 16-bit
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tuser;    // [0] start_of_file
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;    // [15:0] pixel_value, [39:16] pixel_address,
                             // [55:40] image_width, [71:56] image_height
    logic [2:0]  m_tuser;    // [2:0] result_kind
    logic        m_tlast;    // last_pixel

    pgmdf_pkg::result_t due_results [$];  // results the parser model has promised
    logic [8:0]  file_q [$];       // {start_of_file, byte} of the next file
    int          bytes_sent;
    int          mismatches;
    int          quiet_cycles;
    int          idle_pct;
    int          stall_pct;
    bit          hold_req;
    pgmdf_pkg::result_t head;

    // parser model state
    pgmdf_pkg::phase_t ps_phase;
    logic [15:0] ps_width;
    logic [15:0] ps_height;
    logic [16:0] ps_maxval;
    logic [23:0] ps_row_base;
    logic [15:0] ps_cols;
    logic [15:0] ps_rows;
    logic [7:0]  ps_high;

    pgm16_stream_deframer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        ps_phase    = pgmdf_pkg::PH_MAGIC_P;
        ps_width    = '0;
        ps_height   = '0;
        ps_maxval   = '0;
        ps_row_base = '0;
        ps_cols     = '0;
        ps_rows     = '0;
        ps_high     = '0;
    endfunction

    // park the parser until the next start of file
    function automatic pgmdf_pkg::result_t flag_error(pgmdf_pkg::kind_t k);
        pgmdf_pkg::result_t r;
        r       = NO_RESULT;
        r.valid = 1'b1;
        r.kind  = k;
        ps_phase = pgmdf_pkg::PH_ERROR;
        return r;
    endfunction

    // advance the model by one accepted byte; return the result it causes
    function automatic pgmdf_pkg::result_t graymap_parse(logic [7:0] b, logic sof);
        pgmdf_pkg::result_t r;
        logic [31:0] acc;
        logic [32:0] frame;
        logic        digit;
        r     = NO_RESULT;
        digit = (b >= pgmdf_pkg::DIGIT_ZERO) && (b <= pgmdf_pkg::DIGIT_NINE);
        acc   = 32'(b - pgmdf_pkg::DIGIT_ZERO);
        if (sof) begin
            clear_parse();
        end
        frame = 33'(ps_width) * 33'(ps_height);
        case (ps_phase)
            pgmdf_pkg::PH_MAGIC_P: begin
                if (b != pgmdf_pkg::BYTE_P) r = flag_error(pgmdf_pkg::KIND_BAD_MAGIC);
                else ps_phase = pgmdf_pkg::PH_MAGIC_5;
            end
            pgmdf_pkg::PH_MAGIC_5: begin
                if (b != pgmdf_pkg::BYTE_5) r = flag_error(pgmdf_pkg::KIND_BAD_MAGIC);
                else ps_phase = pgmdf_pkg::PH_MAGIC_LF;
            end
            pgmdf_pkg::PH_MAGIC_LF: begin
                if (b != pgmdf_pkg::LINE_FEED) r = flag_error(pgmdf_pkg::KIND_BAD_MAGIC);
                else ps_phase = pgmdf_pkg::PH_WIDTH;
            end
            pgmdf_pkg::PH_WIDTH: begin
                acc = acc + 32'(ps_width) * 32'd10;
                if (b == pgmdf_pkg::SPACE_BYTE) ps_phase = pgmdf_pkg::PH_HEIGHT;
                else if (!digit) r = flag_error(pgmdf_pkg::KIND_BAD_NUMBER);
                else if (acc > 32'(pgmdf_pkg::DIM_LIMIT))
                    r = flag_error(pgmdf_pkg::KIND_TOO_LARGE);
                else ps_width = acc[15:0];
            end
            pgmdf_pkg::PH_HEIGHT: begin
                acc = acc + 32'(ps_height) * 32'd10;
                if (b == pgmdf_pkg::LINE_FEED) ps_phase = pgmdf_pkg::PH_MAXVAL;
                else if (!digit) r = flag_error(pgmdf_pkg::KIND_BAD_NUMBER);
                else if (acc > 32'(pgmdf_pkg::DIM_LIMIT))
                    r = flag_error(pgmdf_pkg::KIND_TOO_LARGE);
                else ps_height = acc[15:0];
            end
            pgmdf_pkg::PH_MAXVAL: begin
                acc = acc + 32'(ps_maxval) * 32'd10;
                if (b == pgmdf_pkg::LINE_FEED) begin
                    if (ps_maxval != pgmdf_pkg::MAXVAL_16BIT) begin
                        r = flag_error(pgmdf_pkg::KIND_NOT16);
                    end else if (frame > pgmdf_pkg::MAX_PIXELS) begin
                        r = flag_error(pgmdf_pkg::KIND_TOO_LARGE);
                    end else begin
                        // first row of the file lands on the highest row index
                        ps_cols     = '0;
                        ps_rows     = ps_height;
                        ps_row_base = (ps_height == 16'd0) ? 24'd0 :
                            24'((32'(ps_height) - 32'd1) * 32'(ps_width));
                        ps_phase    = (frame == '0) ? pgmdf_pkg::PH_DONE :
                                                      pgmdf_pkg::PH_PIX_HIGH;
                        r.valid        = 1'b1;
                        r.kind         = pgmdf_pkg::KIND_HEADER;
                        r.image_width  = ps_width;
                        r.image_height = ps_height;
                    end
                end else if (!digit) begin
                    r = flag_error(pgmdf_pkg::KIND_BAD_NUMBER);
                end else begin
                    // saturate so a huge maxval still fails the 16-bit check
                    ps_maxval = (acc > 32'(pgmdf_pkg::MAXVAL_SAT)) ?
                                pgmdf_pkg::MAXVAL_SAT[16:0] : acc[16:0];
                end
            end
            pgmdf_pkg::PH_PIX_HIGH: begin
                ps_high  = b;
                ps_phase = pgmdf_pkg::PH_PIX_LOW;
            end
            pgmdf_pkg::PH_PIX_LOW: begin
                r.valid         = 1'b1;
                r.kind          = pgmdf_pkg::KIND_PIXEL;
                r.pixel_value   = {ps_high, b};
                r.pixel_address = ps_row_base + 24'(ps_cols);
                ps_cols  = ps_cols + 16'd1;
                ps_phase = pgmdf_pkg::PH_PIX_HIGH;
                if (ps_cols >= ps_width) begin
                    // row done: step the base one row down
                    ps_cols     = '0;
                    ps_rows     = ps_rows - 16'd1;
                    ps_row_base = ps_row_base - 24'(ps_width);
                    if (ps_rows == 16'd0) begin
                        r.last_pixel = 1'b1;
                        ps_phase     = pgmdf_pkg::PH_DONE;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // File building
    // ------------------------------------------------------------------
    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) file_q.push_back({1'b0, s[i]});
    endfunction

    // decimal text, sometimes with a leading zero; a zero may come out empty
    function automatic string dec(int unsigned n);
        string s;
        s = $sformatf("%0d", n);
        if (n == 0 && $urandom_range(1) == 0) s = "";
        else if ($urandom_range(7) == 0) s = {"0", s};
        return s;
    endfunction

    // magic and the three numbers; a corrupt byte cuts the header short
    function automatic void put_header(string ws, string hs, string ms,
                                       int bad_field, logic [7:0] bad);
        put_text("P5\n");
        put_text(ws);
        if (bad_field == FIELD_WIDTH) begin
            file_q.push_back({1'b0, bad});
            return;
        end
        file_q.push_back({1'b0, pgmdf_pkg::SPACE_BYTE});
        put_text(hs);
        if (bad_field == FIELD_HEIGHT) begin
            file_q.push_back({1'b0, bad});
            return;
        end
        file_q.push_back({1'b0, pgmdf_pkg::LINE_FEED});
        put_text(ms);
        if (bad_field == FIELD_MAXVAL) begin
            file_q.push_back({1'b0, bad});
            return;
        end
        file_q.push_back({1'b0, pgmdf_pkg::LINE_FEED});
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one item, idle at random first, predict on acceptance
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic sof,
                             output pgmdf_pkg::result_t want);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        do @(posedge aclk); while (!s_tready);
        want = graymap_parse(b, sof);
        bytes_sent++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                // hold off while the sender keeps offering; the block backs up
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual kind %0d",
                         $time, m_tuser);
                mismatches++;
            end else begin
                head = due_results.pop_front();
                check_field("result_kind",   32'(head.kind),          32'(m_tuser));
                check_field("pixel_value",   32'(head.pixel_value),   32'(m_tdata[15:0]));
                check_field("pixel_address", 32'(head.pixel_address), 32'(m_tdata[39:16]));
                check_field("image_width",   32'(head.image_width),   32'(m_tdata[55:40]));
                check_field("image_height",  32'(head.image_height),  32'(m_tdata[71:56]));
                check_field("last_pixel",    32'(head.last_pixel),    32'(m_tlast));
            end
        end
    end

    // drop the run when no item moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG) begin
                $display("%0t watchdog: no item moved for %0d cycles", $time, WATCHDOG);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        pgmdf_pkg::result_t want;
        scen_t       sc;
        int unsigned files;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned k;
        int          f;
        int          phase_no;
        int          new_phase;
        logic [7:0]  b;

        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= 1'b0;
        bytes_sent   = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_req     = 1'b0;
        clear_parse();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (dir_table[i]) begin
            send_byte(dir_table[i].data, dir_table[i].sof, want);
            if (dir_table[i].typed) want = dir_table[i].res;
            if (want.valid) due_results.push_back(want);
        end

        // random files; idling phases advance with the byte count
        files    = 0;
        phase_no = 0;
        while (bytes_sent < DIRECTED_ROWS + N_ITEMS) begin
            new_phase = (bytes_sent - DIRECTED_ROWS) * 4 / N_ITEMS;
            if (new_phase > 3) new_phase = 3;
            if (new_phase != phase_no) begin
                // pause the sender until every promised result is out
                phase_no = new_phase;
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (due_results.size() != 0);
            end
            case (phase_no)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 60; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase

            // walk every file kind once, then weight toward good frames
            if (files < SC_COUNT) begin
                sc = scen_t'(files);
            end else begin
                k = $urandom_range(99);
                if (k < 40)      sc = SC_GOOD;
                else if (k < 55) sc = SC_WIDE;
                else if (k < 63) sc = SC_TRUNC;
                else if (k < 69) sc = SC_BAD_MAGIC;
                else if (k < 75) sc = SC_BAD_NUMBER;
                else if (k < 80) sc = SC_OVERFLOW;
                else if (k < 86) sc = SC_MAXVAL;
                else if (k < 91) sc = SC_TOO_LARGE;
                else if (k < 94) sc = SC_BOUNDARY;
                else             sc = SC_NOISE;
            end
            if (files == SC_COUNT) begin
                // long receiver hold-off over a pixel-heavy file
                sc       = SC_WIDE;
                hold_req = 1'b1;
            end

            file_q = {};
            case (sc)
                SC_GOOD, SC_WIDE, SC_TRUNC: begin
                    if (sc == SC_WIDE) begin
                        w = $urandom_range(8, 24);
                        h = $urandom_range(1, 3);
                    end else begin
                        w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
                        h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
                    end
                    put_header(dec(w), dec(h), dec(pgmdf_pkg::MAXVAL_16BIT),
                               NO_FIELD, 8'h00);
                    repeat (2 * w * h) file_q.push_back({1'b0, 8'($urandom)});
                end
                SC_BAD_MAGIC: begin
                    put_header(dec(2), dec(2), dec(pgmdf_pkg::MAXVAL_16BIT),
                               NO_FIELD, 8'h00);
                    k = $urandom_range(2);
                    do b = 8'($urandom); while (b == file_q[k][7:0]);
                    file_q[k] = {1'b0, b};
                end
                SC_BAD_NUMBER: begin
                    f = $urandom_range(FIELD_MAXVAL, FIELD_WIDTH);
                    if ($urandom_range(3) == 0) begin
                        // the other field's terminator is a bad byte too
                        b = (f == FIELD_WIDTH) ? pgmdf_pkg::LINE_FEED :
                                                 pgmdf_pkg::SPACE_BYTE;
                    end else begin
                        do b = 8'($urandom);
                        while ((b >= pgmdf_pkg::DIGIT_ZERO && b <= pgmdf_pkg::DIGIT_NINE) ||
                               b == pgmdf_pkg::SPACE_BYTE || b == pgmdf_pkg::LINE_FEED);
                    end
                    put_header(dec($urandom_range(300)), dec($urandom_range(300)),
                               dec($urandom_range(70000)), f, b);
                end
                SC_OVERFLOW: begin
                    n = $urandom_range(65536, 999999);
                    if ($urandom_range(1) == 0)
                        put_header(dec(n), dec(3), dec(pgmdf_pkg::MAXVAL_16BIT),
                                   NO_FIELD, 8'h00);
                    else
                        put_header(dec(3), dec(n), dec(pgmdf_pkg::MAXVAL_16BIT),
                                   NO_FIELD, 8'h00);
                end
                SC_MAXVAL: begin
                    case ($urandom_range(2))
                        0:       n = $urandom_range(65534);
                        1:       n = 65536;
                        default: n = $urandom_range(65537, 99999999);
                    endcase
                    put_header(dec(2), dec(2), dec(n), NO_FIELD, 8'h00);
                end
                SC_TOO_LARGE, SC_BOUNDARY: begin
                    if (sc == SC_BOUNDARY) begin
                        // frames at or just under the size limit are accepted
                        if ($urandom_range(1) == 0) begin
                            w = 4096;
                            h = 4096;
                        end else begin
                            w = 65535;
                            h = 256;
                        end
                    end else if ($urandom_range(1) == 0) begin
                        w = 65535;
                        h = $urandom_range(257, 65535);
                    end else begin
                        w = $urandom_range(4097, 65535);
                        h = 16777216 / w + 1;
                    end
                    if ($urandom_range(1) == 0)
                        put_header(dec(w), dec(h), dec(pgmdf_pkg::MAXVAL_16BIT),
                                   NO_FIELD, 8'h00);
                    else
                        put_header(dec(h), dec(w), dec(pgmdf_pkg::MAXVAL_16BIT),
                                   NO_FIELD, 8'h00);
                    // a huge frame is cut short; the next file restarts it
                    if (sc == SC_BOUNDARY)
                        repeat ($urandom_range(2, 60)) file_q.push_back({1'b0, 8'($urandom)});
                end
                default: begin
                    repeat ($urandom_range(4, 12))
                        file_q.push_back({$urandom_range(4) == 0,
                                          ($urandom_range(2) == 0) ? pgmdf_pkg::BYTE_P :
                                                                     8'($urandom)});
                end
            endcase
            // trailing bytes land after the frame, in the error hold, or among the pixels of a frame cut short
            repeat ($urandom_range(3)) file_q.push_back({1'b0, 8'($urandom)});
            if (sc == SC_TRUNC) begin
                k = $urandom_range(1, file_q.size());
                while (file_q.size() > k) void'(file_q.pop_back());
            end

            foreach (file_q[i]) begin
                send_byte(file_q[i][7:0], file_q[i][8] | (i == 0), want);
                if (want.valid) due_results.push_back(want);
            end
            files++;
        end

        // drain: wait for every promised result, then let the bench idle before the verdict
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (due_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
